// File: rtl/vot_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and handshake structs for the offset translation cache.
// Used by vot_divider, vot_cache and virtual_offset_translate_cache.
package vot_pkg;

	localparam int CACHE_ENTRIES_DEF = 16;

	localparam int OFF_W    = 48;
	localparam int BASE_W   = 56;
	localparam int IDX_W    = 49;
	localparam int RSZ_W    = 32;
	localparam int FIRST_W  = 32;
	localparam int STATUS_W = 3;

	// offsets must be a multiple of 8 bits
	localparam int ALIGN_LSB = 3;

	// APB: 64-bit data, registers at 8-byte spacing
	localparam int APB_DW      = 64;
	localparam int APB_AW      = 5;
	localparam int APB_IDX_LSB = 3;
	localparam int REG_IDX_W   = APB_AW - APB_IDX_LSB;

	localparam logic [REG_IDX_W-1:0] REG_TOTAL = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_RSZ   = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_FIRST = REG_IDX_W'(2);

	localparam logic [RSZ_W-1:0] RSZ_RESET = RSZ_W'(8);

	localparam logic ACTION_TRANSLATE = 1'b0;
	localparam logic ACTION_FILL      = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_MISS  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_RANGE = STATUS_W'(2);
	localparam logic [STATUS_W-1:0] ST_ALIGN = STATUS_W'(3);
	localparam logic [STATUS_W-1:0] ST_STRAY = STATUS_W'(4);
	localparam logic [STATUS_W-1:0] ST_BUSY  = STATUS_W'(5);

	localparam int DIV_CNT_W = $clog2(IDX_W + 1);

	typedef struct packed {
		logic             start;
		logic [IDX_W-1:0] dividend;
		logic [RSZ_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] quotient;
		logic [RSZ_W-1:0] remainder;
	} div_rsp_t;

endpackage

// File: rtl/vot_divider.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle, 49-bit dividend.
// Depends on vot_pkg for widths and the request/response structs.
module vot_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  vot_pkg::div_req_t req,
	output vot_pkg::div_rsp_t rsp
);
	import vot_pkg::*;

	logic [IDX_W-1:0]     dvd_q;
	logic [RSZ_W-1:0]     dsr_q;
	logic [RSZ_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;

	logic [RSZ_W:0]   trial;
	logic [RSZ_W:0]   diff;
	logic             q_bit;
	logic [RSZ_W-1:0] nxt_rem;

	always_comb begin
		trial   = {rem_q, dvd_q[IDX_W-1]};
		diff    = trial - {1'b0, dsr_q};
		q_bit   = ~diff[RSZ_W];
		nxt_rem = q_bit ? diff[RSZ_W-1:0] : trial[RSZ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (req.start) begin
				dvd_q  <= req.dividend;
				dsr_q  <= req.divisor;
				rem_q  <= '0;
				cnt_q  <= DIV_CNT_W'(IDX_W);
				done_q <= 1'b0;
			end else if (cnt_q != '0) begin
				// quotient bits shift in behind the dividend
				dvd_q  <= {dvd_q[IDX_W-2:0], q_bit};
				rem_q  <= nxt_rem;
				cnt_q  <= cnt_q - DIV_CNT_W'(1);
				done_q <= (cnt_q == DIV_CNT_W'(1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

// File: rtl/vot_cache.sv
`timescale 1ns / 1ps
// Direct-mapped entry store (valid, tag, base) with registered read and tag compare.
// Depends on vot_pkg for field widths.
module vot_cache #(
	parameter int ENTRIES = vot_pkg::CACHE_ENTRIES_DEF,
	parameter int SLOT_W  = 4
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [SLOT_W-1:0]         waddr,
	input  logic                      wvalid,
	input  logic [vot_pkg::IDX_W-1:0]  wtag,
	input  logic [vot_pkg::BASE_W-1:0] wbase,
	input  logic                      re,
	input  logic [SLOT_W-1:0]         raddr,
	input  logic [vot_pkg::IDX_W-1:0]  ctag,
	output logic                      hit,
	output logic [vot_pkg::BASE_W-1:0] rbase
);
	import vot_pkg::*;

	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  tag;
		logic [BASE_W-1:0] base;
	} row_t;

	row_t mem [0:ENTRIES-1];
	row_t row_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= '{valid: wvalid, tag: wtag, base: wbase};
	end

	always_ff @(posedge clk) begin
		if (re)
			row_q <= mem[raddr];
	end

	assign hit   = row_q.valid && (row_q.tag == ctag);
	assign rbase = row_q.base;

endmodule

// File: rtl/virtual_offset_translate_cache.sv
`timescale 1ns / 1ps
// Top level: APB registers, sequencer, shared serial divider and entry store.
// Depends on vot_pkg, vot_divider and vot_cache.
//
//  channel  | signals                                   | transfer on
//  ---------+-------------------------------------------+----------------------------
//  request  | action, virtual_offset, fill_base         | req_valid & req_ready
//  response | status, physical_offset, miss_index       | rsp_valid & rsp_ready
//  config   | psel, penable, pwrite, paddr, pwdata/prdata| psel & penable & pwrite
//
//  A translate runs the serial divider, one bit a cycle, for offset / record size;
//  when CACHE_ENTRIES is not a power of two it runs it again for the slot (index
//  modulo CACHE_ENTRIES), else the slot is the low bits of the index. Fills and
//  rejected transactions go straight to the response. After reset a clearing pass
//  invalidates every entry; req_ready stays low meanwhile. A stalled response waits
//  in its output register while the next transaction is accepted and worked on.
module virtual_offset_translate_cache #(
	parameter int CACHE_ENTRIES = vot_pkg::CACHE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vot_pkg::APB_AW-1:0]   paddr,
	input  logic [vot_pkg::APB_DW-1:0]   pwdata,
	output logic [vot_pkg::APB_DW-1:0]   prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic                        action,
	input  logic [vot_pkg::OFF_W-1:0]    virtual_offset,
	input  logic [vot_pkg::BASE_W-1:0]   fill_base,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [vot_pkg::STATUS_W-1:0] status,
	output logic [vot_pkg::BASE_W-1:0]   physical_offset,
	output logic [vot_pkg::IDX_W-1:0]    miss_index
);
	import vot_pkg::*;

	localparam int SLOT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam bit SLOT_POW2 = ((CACHE_ENTRIES & (CACHE_ENTRIES - 1)) == 0);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_ENTRIES - 1);
	localparam logic [RSZ_W-1:0] ENTRIES_DSR = RSZ_W'(CACHE_ENTRIES);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DIV, S_SLOT, S_MOD, S_READ, S_CMP, S_OUT
	} state_t;

	// configuration registers
	logic [OFF_W-1:0]   total_q;
	logic [RSZ_W-1:0]   rsz_q;
	logic [FIRST_W-1:0] first_q;
	logic [REG_IDX_W-1:0] reg_idx;

	assign reg_idx = paddr[APB_AW-1:APB_IDX_LSB];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			rsz_q   <= RSZ_RESET;
			first_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_TOTAL: total_q <= pwdata[OFF_W-1:0];
				REG_RSZ:   rsz_q   <= pwdata[RSZ_W-1:0];
				REG_FIRST: first_q <= pwdata[FIRST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TOTAL: prdata = APB_DW'(total_q);
			REG_RSZ:   prdata = APB_DW'(rsz_q);
			REG_FIRST: prdata = APB_DW'(first_q);
			default:   prdata = '0;
		endcase
	end

	// sequencer state
	state_t              state_q;
	logic [SLOT_W-1:0]   clr_q;
	logic [IDX_W-1:0]    idx_q;
	logic [RSZ_W-1:0]    rem_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                pend_q;
	logic [IDX_W-1:0]    pend_idx_q;
	logic [RSZ_W-1:0]    pend_rem_q;
	logic [SLOT_W-1:0]   pend_slot_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [BASE_W-1:0]   res_phys_q;
	logic [IDX_W-1:0]    res_midx_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [BASE_W-1:0]   phys_q;
	logic [IDX_W-1:0]    midx_q;

	logic              req_fire;
	logic              translate_ok;
	logic [IDX_W-1:0]  idx_sum;
	logic [SLOT_W-1:0] slot_fold;
	logic [BASE_W-1:0] fill_phys;
	logic [BASE_W-1:0] hit_phys;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	logic              mem_hit;
	logic [BASE_W-1:0] mem_base;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;

	assign translate_ok = !pend_q
		&& (virtual_offset[ALIGN_LSB-1:0] == '0)
		&& (virtual_offset < total_q)
		&& (rsz_q != '0);

	assign idx_sum   = div_rsp.quotient + IDX_W'(first_q);
	assign fill_phys = fill_base + BASE_W'(pend_rem_q);
	assign hit_phys  = mem_base + BASE_W'(rem_q);

	always_comb begin
		if (SLOT_POW2 && (CACHE_ENTRIES > 1))
			slot_fold = idx_q[SLOT_W-1:0];
		else
			slot_fold = '0;
	end

	// the divider is shared: offset / record size, then (entries not a power of two) index modulo entries
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = idx_q;
		div_req.divisor  = ENTRIES_DSR;
		if (state_q == S_IDLE) begin
			div_req.start    = req_fire && (action == ACTION_TRANSLATE) && translate_ok;
			div_req.dividend = IDX_W'(virtual_offset);
			div_req.divisor  = rsz_q;
		end else if (state_q == S_SLOT) begin
			div_req.start = !SLOT_POW2;
		end
	end

	vot_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign mem_we = (state_q == S_CLEAR)
		|| (req_fire && (action == ACTION_FILL) && pend_q);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_q : pend_slot_q;

	vot_cache #(
		.ENTRIES (CACHE_ENTRIES),
		.SLOT_W  (SLOT_W)
	) u_cache (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wvalid (state_q != S_CLEAR),
		.wtag   (pend_idx_q),
		.wbase  (fill_base),
		.re     (state_q == S_READ),
		.raddr  (slot_q),
		.ctag   (idx_q),
		.hit    (mem_hit),
		.rbase  (mem_base)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			idx_q        <= '0;
			rem_q        <= '0;
			slot_q       <= '0;
			pend_q       <= 1'b0;
			pend_idx_q   <= '0;
			pend_rem_q   <= '0;
			pend_slot_q  <= '0;
			res_status_q <= ST_OK;
			res_phys_q   <= '0;
			res_midx_q   <= '0;
			rsp_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			phys_q       <= '0;
			midx_q       <= '0;
		end else begin
			// S_OUT handles the output register itself
			if (rsp_valid_q && rsp_ready && (state_q != S_OUT))
				rsp_valid_q <= 1'b0;

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == LAST_SLOT)
						state_q <= S_IDLE;
				end
				S_IDLE: if (req_fire) begin
					res_midx_q <= '0;
					res_phys_q <= ((action == ACTION_FILL) && pend_q) ? fill_phys : '0;
					if (action == ACTION_FILL) begin
						state_q <= S_OUT;
						if (!pend_q) begin
							res_status_q <= ST_STRAY;
						end else begin
							res_status_q <= ST_OK;
							pend_q       <= 1'b0;
						end
					end else if (pend_q) begin
						state_q      <= S_OUT;
						res_status_q <= ST_BUSY;
					end else if (virtual_offset[ALIGN_LSB-1:0] != '0) begin
						state_q      <= S_OUT;
						res_status_q <= ST_ALIGN;
					end else if (!translate_ok) begin
						state_q      <= S_OUT;
						res_status_q <= ST_RANGE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: if (div_rsp.done) begin
					idx_q   <= idx_sum;
					rem_q   <= div_rsp.remainder;
					state_q <= S_SLOT;
				end
				S_SLOT: begin
					if (SLOT_POW2) begin
						slot_q  <= slot_fold;
						state_q <= S_READ;
					end else begin
						state_q <= S_MOD;
					end
				end
				S_MOD: if (div_rsp.done) begin
					slot_q  <= div_rsp.remainder[SLOT_W-1:0];
					state_q <= S_READ;
				end
				S_READ: state_q <= S_CMP;
				S_CMP: begin
					state_q    <= S_OUT;
					res_midx_q <= mem_hit ? '0 : idx_q;
					res_phys_q <= mem_hit ? hit_phys : '0;
					if (mem_hit) begin
						res_status_q <= ST_OK;
					end else begin
						// hold the miss until its fill arrives
						res_status_q <= ST_MISS;
						pend_q       <= 1'b1;
						pend_idx_q   <= idx_q;
						pend_rem_q   <= rem_q;
						pend_slot_q  <= slot_q;
					end
				end
				S_OUT: if (!rsp_valid_q || rsp_ready) begin
					rsp_valid_q <= 1'b1;
					status_q    <= res_status_q;
					phys_q      <= res_phys_q;
					midx_q      <= res_midx_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign physical_offset = phys_q;
	assign miss_index      = midx_q;

	a_div_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV || state_q == S_MOD))
		else $error("divider finished outside a divide step");

	a_mem_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || state_q == S_IDLE))
		else $error("entry store written outside clear or fill");

	a_midx_only_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q != ST_MISS) |-> (midx_q == '0))
		else $error("miss index set on a non-miss response");

	a_phys_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q != ST_OK) |-> (phys_q == '0))
		else $error("physical offset set on a failed response");

endmodule
